@@ rtl/mlt_pkg.sv @@
// ----------------------------------------------------------------------------
// mlt_pkg: line tokenizer shared definitions
// Widths, token kinds, scan modes, the result record and character helpers.
// ----------------------------------------------------------------------------
package mlt_pkg;

   localparam int LINE_LEN    = 256;
   localparam int MAX_IDENT   = 255;
   localparam int LINE_POS_W  = $clog2(LINE_LEN);
   localparam int HEX_DIGITS  = 6;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

   typedef logic [7:0]              char_type;
   typedef logic [4:0]              kind_type;
   typedef logic [7:0]              pos_type;
   typedef logic [7:0]              len_type;
   typedef logic [23:0]             value_type;
   typedef logic [LINE_POS_W-1:0]   line_pos_type;
   typedef logic [FIFO_PTR_W-1:0]   fifo_ptr_type;
   typedef logic [FIFO_CNT_W-1:0]   fifo_cnt_type;

   // token kinds
   localparam kind_type KIND_EOL      = 5'd0;
   localparam kind_type KIND_CONST8   = 5'd1;
   localparam kind_type KIND_CONST16  = 5'd2;
   localparam kind_type KIND_CONST24  = 5'd3;
   localparam kind_type KIND_COMMAND  = 5'd4;
   localparam kind_type KIND_SREG     = 5'd5;
   localparam kind_type KIND_XREG     = 5'd6;
   localparam kind_type KIND_YREG     = 5'd7;
   localparam kind_type KIND_MNEMONIC = 5'd8;
   localparam kind_type KIND_STRING   = 5'd9;
   localparam kind_type KIND_SLASH    = 5'd10;
   localparam kind_type KIND_COLON    = 5'd11;
   localparam kind_type KIND_HASH     = 5'd12;
   localparam kind_type KIND_COMMA    = 5'd13;
   localparam kind_type KIND_LPAREN   = 5'd14;
   localparam kind_type KIND_RPAREN   = 5'd15;
   localparam kind_type KIND_LBRACK   = 5'd16;
   localparam kind_type KIND_RBRACK   = 5'd17;
   localparam kind_type KIND_DOT      = 5'd18;
   localparam kind_type KIND_EQUALS   = 5'd19;
   localparam kind_type KIND_BANG     = 5'd20;
   localparam kind_type KIND_ERROR    = 5'd21;

   localparam char_type CHAR_QUOTE = 8'h27;
   localparam char_type CHAR_S     = 8'h53;
   localparam char_type CHAR_X     = 8'h58;
   localparam char_type CHAR_Y     = 8'h59;
   localparam char_type CASE_BIT   = 8'h20;

   typedef enum logic [3:0] {
      MODE_IDLE  = 4'b0001,
      MODE_HEX   = 4'b0010,
      MODE_IDENT = 4'b0100,
      MODE_STR   = 4'b1000
   } mode_type;

   typedef struct packed {
      kind_type  kind;
      pos_type   position;
      len_type   length;
      value_type value;
      logic      last;
   } result_type;

   function automatic logic is_digit(input char_type c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input char_type c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

   function automatic logic is_hex(input char_type c);
      return is_digit(c) || ((c >= 8'h41) && (c <= 8'h46)) ||
             ((c >= 8'h61) && (c <= 8'h66));
   endfunction

   function automatic logic is_blank(input char_type c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic char_type to_upper(input char_type c);
      return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - CASE_BIT) : c;
   endfunction

   function automatic logic [3:0] hex_val(input char_type c);
      char_type u;
      char_type d;
      u = to_upper(c);
      d = is_digit(u) ? (u - 8'h30) : (u - 8'h37);
      return d[3:0];
   endfunction

   // punctuation lookup: hit flag and kind
   function automatic logic [5:0] punct_lookup(input char_type c);
      logic     hit;
      kind_type k;
      hit = 1'b1;
      k   = KIND_ERROR;
      case (c)
         8'h2F:   k = KIND_SLASH;
         8'h3A:   k = KIND_COLON;
         8'h23:   k = KIND_HASH;
         8'h2C:   k = KIND_COMMA;
         8'h28:   k = KIND_LPAREN;
         8'h29:   k = KIND_RPAREN;
         8'h5B:   k = KIND_LBRACK;
         8'h5D:   k = KIND_RBRACK;
         8'h2E:   k = KIND_DOT;
         8'h3D:   k = KIND_EQUALS;
         8'h21:   k = KIND_BANG;
         default: hit = 1'b0;
      endcase
      return {hit, k};
   endfunction

endpackage

@@ rtl/mlt_req_if.sv @@
// ----------------------------------------------------------------------------
// mlt_req_if: character channel
// One line character or a line-end mark per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mlt_req_if;
   logic              valid;
   logic              ready;
   mlt_pkg::char_type ch;
   logic              line_end;
   logic              no_const;

   modport source (output valid, ch, line_end, no_const, input ready);
   modport sink   (input valid, ch, line_end, no_const, output ready);
endinterface

@@ rtl/mlt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// mlt_rsp_if: token channel
// One token per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mlt_rsp_if;
   logic               valid;
   logic               ready;
   mlt_pkg::kind_type  kind;
   mlt_pkg::pos_type   position;
   mlt_pkg::len_type   length;
   mlt_pkg::value_type value;
   logic               last;

   modport source (output valid, kind, position, length, value, last, input ready);
   modport sink   (input valid, kind, position, length, value, last, output ready);
endinterface

@@ rtl/monitor_line_tokenizer.sv @@
// ----------------------------------------------------------------------------
// monitor_line_tokenizer: character stream to token stream
// Scans a line one character per beat and emits hex literals, identifiers,
// strings, punctuation, errors and the end-of-line token.
// ----------------------------------------------------------------------------
// Usage
//   req_bus takes one character per beat, or a line-end mark. no_const is
//   looked at only when a token starts.
//   rsp_bus gives tokens in line order; last marks the final token that a
//   character beat caused. A beat causes zero, one or two tokens.
//   Latency: a token produced by a beat is visible on rsp_bus the cycle after
//   that beat is taken, once older tokens in the queue have drained. Pending
//   literals and identifiers stay in the scan state until a character or a line-end
//   mark that ends them arrives.
//   Throughput: one character per cycle. The scan state updates in the same
//   cycle the beat is taken; tokens enter a four-entry result queue, and a
//   beat is taken while at least two entries are free, so the rate is set by
//   the token side draining one token per cycle.
//   Reset clears the scan state, the line position and the result queue.
//   When the receiver stalls, the queue fills and req_bus.ready drops once
//   fewer than two entries are free; nothing is lost.
// ----------------------------------------------------------------------------
module monitor_line_tokenizer (
   input  logic         clock,
   input  logic         reset,
   mlt_req_if.sink      req_bus,
   mlt_rsp_if.source    rsp_bus
);

   localparam mlt_pkg::line_pos_type LAST_POS  = mlt_pkg::line_pos_type'(mlt_pkg::LINE_LEN - 1);
   localparam mlt_pkg::len_type      IDENT_MAX = mlt_pkg::len_type'(mlt_pkg::MAX_IDENT);
   localparam mlt_pkg::len_type      HEX_MAX   = mlt_pkg::len_type'(mlt_pkg::HEX_DIGITS);
   localparam mlt_pkg::len_type      STR_MAX   = 8'd255;
   localparam mlt_pkg::fifo_cnt_type FIFO_ROOM =
      mlt_pkg::fifo_cnt_type'(mlt_pkg::FIFO_DEPTH - 2);
   localparam mlt_pkg::fifo_cnt_type FIFO_FULL =
      mlt_pkg::fifo_cnt_type'(mlt_pkg::FIFO_DEPTH);

   // scan state
   mlt_pkg::mode_type     mode_ff, mode_in;
   mlt_pkg::line_pos_type line_pos_ff, line_pos_in;
   mlt_pkg::line_pos_type tok_start_ff, tok_start_in;
   mlt_pkg::len_type      tok_count_ff, tok_count_in;
   mlt_pkg::value_type    accum_ff, accum_in;
   logic                  skip_ff, skip_in;

   // result queue
   mlt_pkg::result_type   fifo_ff [mlt_pkg::FIFO_DEPTH];
   mlt_pkg::fifo_ptr_type wr_ptr_ff, wr_ptr_in;
   mlt_pkg::fifo_ptr_type rd_ptr_ff, rd_ptr_in;
   mlt_pkg::fifo_cnt_type cnt_ff, cnt_in;

   logic                  accept;
   logic                  pop;
   logic                  flush_emit;
   logic                  tail_emit;
   mlt_pkg::result_type   flush_res;
   mlt_pkg::result_type   tail_res;
   mlt_pkg::result_type   res0;
   mlt_pkg::result_type   res1;
   logic                  push0;
   logic                  push1;
   logic [5:0]            punct;
   mlt_pkg::char_type     c;

   assign req_bus.ready = (cnt_ff <= FIFO_ROOM);
   assign accept        = req_bus.valid && req_bus.ready;
   assign pop           = rsp_bus.valid && rsp_bus.ready;
   assign c             = req_bus.ch;
   assign punct         = mlt_pkg::punct_lookup(c);

   // token that the pending scan state turns into when it is ended
   always_comb begin
      flush_res          = '0;
      flush_res.position = mlt_pkg::pos_type'(tok_start_ff);
      flush_res.length   = tok_count_ff;
      unique case (mode_ff)
         mlt_pkg::MODE_HEX: begin
            flush_res.value = accum_ff;
            if (tok_count_ff <= 8'd2) begin
               flush_res.kind = mlt_pkg::KIND_CONST8;
            end else if (tok_count_ff <= 8'd4) begin
               flush_res.kind = mlt_pkg::KIND_CONST16;
            end else begin
               flush_res.kind = mlt_pkg::KIND_CONST24;
            end
         end
         mlt_pkg::MODE_IDENT: begin
            flush_res.kind = mlt_pkg::KIND_ERROR;
            if (tok_count_ff == 8'd1) begin
               flush_res.value = accum_ff;
               if (accum_ff == mlt_pkg::value_type'(mlt_pkg::CHAR_S)) begin
                  flush_res.kind = mlt_pkg::KIND_SREG;
               end else if (accum_ff == mlt_pkg::value_type'(mlt_pkg::CHAR_X)) begin
                  flush_res.kind = mlt_pkg::KIND_XREG;
               end else if (accum_ff == mlt_pkg::value_type'(mlt_pkg::CHAR_Y)) begin
                  flush_res.kind = mlt_pkg::KIND_YREG;
               end else begin
                  flush_res.kind = mlt_pkg::KIND_COMMAND;
               end
            end else if (tok_count_ff == 8'd3) begin
               flush_res.kind  = mlt_pkg::KIND_MNEMONIC;
               flush_res.value = accum_ff;
            end
         end
         mlt_pkg::MODE_STR: begin
            flush_res.kind = mlt_pkg::KIND_STRING;
         end
         default: begin
            flush_res.kind = mlt_pkg::KIND_ERROR;
         end
      endcase
   end

   // per-character scan step
   always_comb begin
      mode_in      = mode_ff;
      line_pos_in  = line_pos_ff;
      tok_start_in = tok_start_ff;
      tok_count_in = tok_count_ff;
      accum_in     = accum_ff;
      skip_in      = skip_ff;
      flush_emit   = 1'b0;
      tail_emit    = 1'b0;
      tail_res     = '0;
      tail_res.last = 1'b1;

      if (accept) begin
         if (req_bus.line_end) begin
            flush_emit        = (mode_ff != mlt_pkg::MODE_IDLE);
            tail_emit         = 1'b1;
            tail_res.kind     = mlt_pkg::KIND_EOL;
            tail_res.position = mlt_pkg::pos_type'(line_pos_ff);
            mode_in      = mlt_pkg::MODE_IDLE;
            line_pos_in  = '0;
            tok_start_in = '0;
            tok_count_in = '0;
            accum_in     = '0;
            skip_in      = 1'b0;
         end else if (!skip_ff && (line_pos_ff < LAST_POS)) begin
            line_pos_in = line_pos_ff + mlt_pkg::line_pos_type'(1);
            if (mode_ff == mlt_pkg::MODE_STR) begin
               if (tok_count_ff < STR_MAX) begin
                  tok_count_in = tok_count_ff + 8'd1;
               end
            end else if ((mode_ff == mlt_pkg::MODE_IDENT) && (tok_count_ff < IDENT_MAX) &&
                         (mlt_pkg::is_alpha(c) || mlt_pkg::is_digit(c))) begin
               accum_in     = {accum_ff[15:0], mlt_pkg::to_upper(c)};
               tok_count_in = tok_count_ff + 8'd1;
            end else if ((mode_ff == mlt_pkg::MODE_HEX) && mlt_pkg::is_hex(c) &&
                         (tok_count_ff < HEX_MAX)) begin
               accum_in     = {accum_ff[19:0], mlt_pkg::hex_val(c)};
               tok_count_in = tok_count_ff + 8'd1;
            end else begin
               // end the pending token; a non-blank character then starts the next one
               flush_emit   = (mode_ff != mlt_pkg::MODE_IDLE);
               mode_in      = mlt_pkg::MODE_IDLE;
               tok_count_in = '0;
               accum_in     = '0;
               if (!mlt_pkg::is_blank(c)) begin
                  tok_start_in      = line_pos_ff;
                  tail_res.position = mlt_pkg::pos_type'(line_pos_ff);
                  tail_res.length   = 8'd1;
                  if (mlt_pkg::is_hex(c) && !req_bus.no_const) begin
                     mode_in      = mlt_pkg::MODE_HEX;
                     tok_count_in = 8'd1;
                     accum_in     = mlt_pkg::value_type'(mlt_pkg::hex_val(c));
                  end else if (mlt_pkg::is_alpha(c)) begin
                     mode_in      = mlt_pkg::MODE_IDENT;
                     tok_count_in = 8'd1;
                     accum_in     = mlt_pkg::value_type'(mlt_pkg::to_upper(c));
                  end else if (c == mlt_pkg::CHAR_QUOTE) begin
                     mode_in = mlt_pkg::MODE_STR;
                  end else if (punct[5]) begin
                     tail_emit     = 1'b1;
                     tail_res.kind = punct[4:0];
                  end else begin
                     tail_emit     = 1'b1;
                     tail_res.kind = mlt_pkg::KIND_ERROR;
                     skip_in       = 1'b1;
                  end
               end
            end
         end
      end
   end

   // results are packed into the queue in order
   always_comb begin
      res0      = flush_emit ? flush_res : tail_res;
      res0.last = flush_emit ? !tail_emit : 1'b1;
      res1      = tail_res;
      push0     = flush_emit || tail_emit;
      push1     = flush_emit && tail_emit;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff + mlt_pkg::fifo_ptr_type'(push0) + mlt_pkg::fifo_ptr_type'(push1);
      rd_ptr_in = rd_ptr_ff + mlt_pkg::fifo_ptr_type'(pop);
      cnt_in    = cnt_ff + mlt_pkg::fifo_cnt_type'(push0) + mlt_pkg::fifo_cnt_type'(push1)
                  - mlt_pkg::fifo_cnt_type'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= mlt_pkg::MODE_IDLE;
         line_pos_ff  <= '0;
         tok_start_ff <= '0;
         tok_count_ff <= '0;
         accum_ff     <= '0;
         skip_ff      <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         cnt_ff       <= '0;
      end else begin
         mode_ff      <= mode_in;
         line_pos_ff  <= line_pos_in;
         tok_start_ff <= tok_start_in;
         tok_count_ff <= tok_count_in;
         accum_ff     <= accum_in;
         skip_ff      <= skip_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         fifo_ff[wr_ptr_ff] <= res0;
      end
      if (push1) begin
         fifo_ff[wr_ptr_ff + mlt_pkg::fifo_ptr_type'(1)] <= res1;
      end
   end

   assign rsp_bus.valid    = (cnt_ff != '0);
   assign rsp_bus.kind     = fifo_ff[rd_ptr_ff].kind;
   assign rsp_bus.position = fifo_ff[rd_ptr_ff].position;
   assign rsp_bus.length   = fifo_ff[rd_ptr_ff].length;
   assign rsp_bus.value    = fifo_ff[rd_ptr_ff].value;
   assign rsp_bus.last     = fifo_ff[rd_ptr_ff].last;

   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FIFO_FULL)
      else $error("result queue overflow");

   a_eol_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.line_end |=> (mode_ff == mlt_pkg::MODE_IDLE) &&
                                     (line_pos_ff == '0) && !skip_ff)
      else $error("line end did not clear scan state");

   a_skip_idle: assert property (@(posedge clock) disable iff (reset)
      skip_ff |-> (mode_ff == mlt_pkg::MODE_IDLE))
      else $error("token pending while skipping to line end");

   a_hex_count: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == mlt_pkg::MODE_HEX) |-> (tok_count_ff != '0) && (tok_count_ff <= HEX_MAX))
      else $error("hex digit count out of range");

endmodule

@@ tb/mlt_token_checker.sv @@
// ----------------------------------------------------------------------------
// mlt_token_checker: token stream scoreboard for the line tokenizer
// Watches the character and token channels, keeps its own scan state to work
// out the tokens each accepted character beat must give, and compares every
// token beat with the oldest outstanding one, field by field.
// ----------------------------------------------------------------------------
module mlt_token_checker
   import mlt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   mlt_req_if   req_mon,
   mlt_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   tokens_due
);

   localparam char_type PUNCT_SET [11] = '{8'h2F, 8'h3A, 8'h23, 8'h2C, 8'h28, 8'h29,
                                           8'h5B, 8'h5D, 8'h2E, 8'h3D, 8'h21};
   localparam int unsigned STRING_CAP = 255;

   result_type  expected_tokens[$];
   result_type  beat_tokens[$];
   mode_type    scan_mode;
   int unsigned line_pos;
   int unsigned tok_start;
   int unsigned tok_count;
   value_type   accum;
   bit          skipping;

   function automatic bit is_dec_digit(input char_type c);
      return (c >= "0") && (c <= "9");
   endfunction

   // folding bit 5 in maps both cases onto the lower-case range
   function automatic bit is_letter(input char_type c);
      return ((c | 8'h20) >= "a") && ((c | 8'h20) <= "z");
   endfunction

   function automatic bit is_hex_char(input char_type c);
      return is_dec_digit(c) || (((c | 8'h20) >= "a") && ((c | 8'h20) <= "f"));
   endfunction

   function automatic bit is_space(input char_type c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic char_type fold_upper(input char_type c);
      return is_letter(c) ? (c & 8'hDF) : c;
   endfunction

   function automatic logic [3:0] nibble_of(input char_type c);
      return is_dec_digit(c) ? c[3:0] : c[3:0] + 4'd9;
   endfunction

   task automatic clear_scan();
      scan_mode = MODE_IDLE;
      tok_count = 0;
      accum     = '0;
   endtask

   // emit whatever token is still open
   task automatic close_token();
      kind_type  k;
      value_type v;
      if (scan_mode == MODE_IDLE) return;
      k = KIND_ERROR;
      v = '0;
      case (scan_mode)
         MODE_HEX: begin
            k = (tok_count <= 2) ? KIND_CONST8 : (tok_count <= 4) ? KIND_CONST16 : KIND_CONST24;
            v = accum;
         end
         MODE_IDENT: begin
            if (tok_count == 1) begin
               case (accum[7:0])
                  CHAR_S:  k = KIND_SREG;
                  CHAR_X:  k = KIND_XREG;
                  CHAR_Y:  k = KIND_YREG;
                  default: k = KIND_COMMAND;
               endcase
               v = accum;
            end else if (tok_count == 3) begin
               k = KIND_MNEMONIC;
               v = accum;
            end
         end
         default: k = KIND_STRING;
      endcase
      beat_tokens.push_back('{k, tok_start[7:0], tok_count[7:0], v, 1'b0});
      clear_scan();
   endtask

   task automatic predict_beat(input char_type c, input logic eol, input logic nc);
      int unsigned pos;
      bit          hit;
      beat_tokens.delete();
      if (eol) begin
         close_token();
         beat_tokens.push_back('{KIND_EOL, line_pos[7:0], 8'd0, 24'd0, 1'b0});
         clear_scan();
         line_pos  = 0;
         tok_start = 0;
         skipping  = 1'b0;
      end else if (!skipping && line_pos < LINE_LEN - 1) begin
         pos = line_pos;
         line_pos++;
         if (scan_mode == MODE_STR) begin
            if (tok_count < STRING_CAP) tok_count++;
         end else if (scan_mode == MODE_IDENT && tok_count < MAX_IDENT &&
                      (is_letter(c) || is_dec_digit(c))) begin
            accum = {accum[15:0], fold_upper(c)};
            tok_count++;
         end else if (scan_mode == MODE_HEX && is_hex_char(c) && tok_count < HEX_DIGITS) begin
            accum = {accum[19:0], nibble_of(c)};
            tok_count++;
         end else begin
            close_token();
            if (!is_space(c)) begin
               tok_start = pos;
               if (is_hex_char(c) && !nc) begin
                  scan_mode = MODE_HEX;
                  tok_count = 1;
                  accum     = {20'd0, nibble_of(c)};
               end else if (is_letter(c)) begin
                  scan_mode = MODE_IDENT;
                  tok_count = 1;
                  accum     = {16'd0, fold_upper(c)};
               end else if (c == CHAR_QUOTE) begin
                  scan_mode = MODE_STR;
                  tok_count = 0;
                  accum     = '0;
               end else begin
                  hit = 1'b0;
                  for (int i = 0; i < 11; i++) begin
                     if (PUNCT_SET[i] == c) begin
                        beat_tokens.push_back('{kind_type'(KIND_SLASH + i), pos[7:0], 8'd1,
                                                24'd0, 1'b0});
                        hit = 1'b1;
                     end
                  end
                  // anything else poisons the rest of the line
                  if (!hit) begin
                     skipping = 1'b1;
                     beat_tokens.push_back('{KIND_ERROR, pos[7:0], 8'd1, 24'd0, 1'b0});
                  end
               end
            end
         end
      end
      if (beat_tokens.size() > 0) beat_tokens[beat_tokens.size() - 1].last = 1'b1;
      foreach (beat_tokens[i]) expected_tokens.push_back(beat_tokens[i]);
   endtask

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         expected_tokens.delete();
         clear_scan();
         line_pos       = 0;
         tok_start      = 0;
         skipping       = 1'b0;
         mismatch_count = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            predict_beat(req_mon.ch, req_mon.line_end, req_mon.no_const);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_tokens.size() == 0) begin
               $error("token beat with none outstanding: kind %0d position %0d",
                      rsp_mon.kind, rsp_mon.position);
               mismatch_count++;
            end else begin
               want = expected_tokens.pop_front();
               check_field("kind", want.kind, rsp_mon.kind);
               check_field("position", want.position, rsp_mon.position);
               check_field("length", want.length, rsp_mon.length);
               check_field("value", want.value, rsp_mon.value);
               check_field("last", want.last, rsp_mon.last);
            end
         end
      end
      tokens_due <= expected_tokens.size();
   end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: line tokenizer testbench
// Drives directed lines covering every token kind and error case, then random
// lines of well-formed tokens mixed with noise, a full-length line among
// them, with random gaps and stalls on both channels. The checker scores the
// token stream; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import mlt_pkg::*;

   localparam int    RANDOM_BEATS = 140;
   localparam string PUNCT_TEXT   = "/:#,()[].=!";
   localparam string REG_TEXT     = "sxySXY";
   localparam char_type BLANK_SET [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

   logic        clock = 1'b0;
   logic        reset;
   int          mismatch_count;
   int          tokens_due;
   int unsigned beats_sent;
   int unsigned budget_end;
   int unsigned calm_at;
   int unsigned gap_odds;
   int unsigned stall_odds;
   int unsigned stall_left = 0;
   bit          calm;

   mlt_req_if req_bus ();
   mlt_rsp_if rsp_bus ();

   monitor_line_tokenizer i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   mlt_token_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .tokens_due     (tokens_due)
   );

   always #2 clock = ~clock;

   // token side: random stall bursts, odds varied per line
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!reset && !calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
         stall_left = $urandom_range(0, 4);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic send_beat(input char_type c, input logic eol, input logic nc);
      if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.ch       <= c;
      req_bus.line_end <= eol;
      req_bus.no_const <= nc;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic send_text(input string s, input logic nc);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0, nc);
   endtask

   task automatic send_eol(input char_type c);
      send_beat(c, 1'b1, 1'(($urandom_range(0, 1))));
   endtask

   function automatic char_type pick_letter();
      return char_type'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25));
   endfunction

   // plain lines hold only tokens and blanks, no strings or noise
   task automatic random_line(input int unsigned target, input bit plain);
      int unsigned len;
      int unsigned pick;
      int unsigned n;
      int unsigned r;
      char_type    c;
      len        = 0;
      gap_odds   = $urandom_range(0, 4) * 2;
      stall_odds = $urandom_range(0, 4) * 2;
      while (len < target) begin
         pick = plain ? $urandom_range(0, 79) : $urandom_range(0, 99);
         if (pick < 25) begin
            // up to seven digits, so a literal may overrun into a new one
            n = $urandom_range(1, 7);
            for (int j = 0; j < n; j++) begin
               r = $urandom_range(0, 15);
               c = char_type'((r < 10) ? "0" + r :
                              ($urandom_range(0, 1) ? "a" : "A") + r - 10);
               send_beat(c, 1'b0, (j == 0) ? 1'b0 : 1'(($urandom_range(0, 1))));
            end
         end else if (pick < 50) begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) :
                ($urandom_range(0, 1) ? 1 : 3);
            for (int j = 0; j < n; j++) begin
               if (j == 0 && $urandom_range(0, 3) == 0)
                  c = REG_TEXT[$urandom_range(0, 5)];
               else if (j == 0 || $urandom_range(0, 3) != 0)
                  c = pick_letter();
               else
                  c = char_type'("0" + $urandom_range(0, 9));
               send_beat(c, 1'b0, (j == 0) ? 1'($urandom_range(0, 3) != 0) :
                                             1'(($urandom_range(0, 1))));
            end
         end else if (pick < 60) begin
            n = 1;
            send_beat(PUNCT_TEXT[$urandom_range(0, 10)], 1'b0, 1'(($urandom_range(0, 1))));
         end else if (pick < 80) begin
            n = $urandom_range(1, 3);
            repeat (n) send_beat(BLANK_SET[$urandom_range(0, 5)], 1'b0, 1'(($urandom_range(0, 1))));
         end else if (pick < 90) begin
            // the rest of the line becomes string content
            n = $urandom_range(0, 8) + 1;
            send_beat(CHAR_QUOTE, 1'b0, 1'(($urandom_range(0, 1))));
            repeat (n - 1) send_beat(char_type'($urandom_range(0, 255)), 1'b0,
                                     1'(($urandom_range(0, 1))));
         end else begin
            n = 1;
            send_beat(char_type'($urandom_range(0, 255)), 1'b0, 1'(($urandom_range(0, 1))));
         end
         len += n;
         if ($urandom_range(0, 1)) begin
            send_beat(8'h20, 1'b0, 1'(($urandom_range(0, 1))));
            len++;
         end
      end
      send_eol(char_type'($urandom_range(0, 255)));
   endtask

   initial begin
      reset            = 1'b1;
      calm             = 1'b0;
      beats_sent       = 0;
      gap_odds         = 0;
      stall_odds       = 0;
      req_bus.valid    = 1'b0;
      req_bus.ch       = '0;
      req_bus.line_end = 1'b0;
      req_bus.no_const = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // every punctuation mark, registers, a command and a mnemonic
      send_text("0,S:x#y(q)[lda]./=!", 1'b0);
      send_eol(8'h00);
      // six-digit literal overrun by a seventh, a four-digit one, a string to line end
      gap_odds   = 3;
      stall_odds = 3;
      send_text("FfFfFf7 c0de\t'", 1'b0);
      send_beat(8'h80, 1'b0, 1'b0);
      send_eol(8'h7F);
      // two-letter identifier, then a digit with no_const set skips the line
      send_text("ab 9zz", 1'b1);
      send_eol(8'hFF);

      budget_end = beats_sent + RANDOM_BEATS / 2;
      while (beats_sent < budget_end) random_line($urandom_range(1, 24), 1'b0);

      // string running past the full line
      send_beat(CHAR_QUOTE, 1'b0, 1'b0);
      repeat (258) send_beat(char_type'($urandom_range(0, 255)), 1'b0, 1'(($urandom_range(0, 1))));
      send_eol(8'h20);

      budget_end = beats_sent + RANDOM_BEATS / 2;
      calm_at    = beats_sent + RANDOM_BEATS / 3;
      while (beats_sent < budget_end) begin
         if (beats_sent > calm_at) calm = 1'b1;
         random_line($urandom_range(1, 24), 1'b0);
      end
      req_bus.valid <= 1'b0;

      @(posedge clock);
      while (tokens_due != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && tokens_due == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
